/* design/gmm_pkg.sv */
`timescale 1ns / 1ps

package gmm_pkg;

  localparam int COMP_W      = 4;
  localparam int NUM_W       = 5;
  localparam int VAL_W       = 16;
  localparam int PREC_W      = 16;
  localparam int CONST_W     = 32;
  localparam int SCORE_W     = 64;
  localparam int LIN_W       = 32;
  localparam int QUAD_W      = 17;
  localparam int XSQ_W       = 31;
  localparam int PLIN_W      = LIN_W + VAL_W;
  localparam int PQUAD_W     = QUAD_W + XSQ_W + 1;
  localparam int ACC_W       = 52;
  localparam int FIELD_REACH = 16;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_SCORE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              load;
    logic              capture;
    logic              issue;
    logic [COMP_W-1:0] comp;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic advance;
    logic busy;
  } dp_status_t;

endpackage

/* design/gmm_ctrl.sv */
`timescale 1ns / 1ps

module gmm_ctrl import gmm_pkg::*; #(
  parameter int MAX_COMPONENTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [NUM_W-1:0] cfg_data,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  localparam int LIM = (MAX_COMPONENTS < FIELD_REACH) ? MAX_COMPONENTS : FIELD_REACH;

  state_t            state;
  state_t            state_next;
  logic [NUM_W-1:0]  num_components;
  logic [COMP_W-1:0] k;
  logic [COMP_W-1:0] k_next;
  logic [NUM_W-1:0]  active;
  logic              accept;
  logic              is_last;

  always_comb begin
    if (num_components == '0) begin
      active = NUM_W'(1);
    end else if (num_components > NUM_W'(LIM)) begin
      active = NUM_W'(LIM);
    end else begin
      active = num_components;
    end
  end

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_last   = ({1'b0, k} == (active - NUM_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      k              <= '0;
      num_components <= NUM_W'(16);
    end else begin
      state <= state_next;
      k     <= k_next;
      if (cfg_valid && cfg_ready) begin
        num_components <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next  = state;
    k_next      = k;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.capture = 1'b0;
    cmd.issue   = 1'b0;
    cmd.comp    = k;
    cmd.last    = is_last;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        k_next   = '0;
        if (accept) begin
          if (action == ACTION_SCORE) begin
            cmd.capture = 1'b1;
            state_next  = ST_PREP;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_PREP: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.advance) begin
          cmd.issue = 1'b1;
          k_next    = k + COMP_W'(1);
          if (is_last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/gmm_datapath.sv */
`timescale 1ns / 1ps

module gmm_datapath import gmm_pkg::*; #(
  parameter int MAX_COMPONENTS = 16,
  parameter int DIMS           = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic [COMP_W-1:0]         component,
  input  logic signed [VAL_W-1:0]   value_0,
  input  logic signed [VAL_W-1:0]   value_1,
  input  logic [PREC_W-1:0]         prec_0,
  input  logic [PREC_W-1:0]         prec_1,
  input  logic signed [CONST_W-1:0] comp_constant,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COMP_W-1:0]         out_component,
  output logic signed [SCORE_W-1:0] score,
  output logic                      last
);

  localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  logic                      advance;
  logic                      write_ok;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;

  logic signed [CONST_W-1:0] const_mem [MAX_COMPONENTS];

  logic                      s1_valid;
  logic [COMP_W-1:0]         s1_comp;
  logic                      s1_last;
  logic signed [CONST_W-1:0] s1_const;
  logic                      s2_valid;
  logic [COMP_W-1:0]         s2_comp;
  logic                      s2_last;
  logic signed [CONST_W-1:0] s2_const;
  logic                      s3_valid;
  logic [COMP_W-1:0]         s3_comp;
  logic                      s3_last;
  logic signed [CONST_W-1:0] s3_const;

  logic signed [ACC_W-1:0]   dim_sum [DIMS];
  logic signed [ACC_W-1:0]   total;
  logic signed [ACC_W-2:0]   half;

  assign advance        = !out_valid || out_ready;
  assign status.advance = advance;
  assign status.busy    = s1_valid || s2_valid || s3_valid || out_valid;
  assign write_ok       = cmd.load && (32'(component) < MAX_COMPONENTS);
  assign waddr          = AW'(component);
  assign raddr          = AW'(cmd.comp);

  always_ff @(posedge clk) begin
    if (write_ok) begin
      const_mem[waddr] <= comp_constant;
    end
  end

  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    logic signed [VAL_W-1:0]   value_in;
    logic [PREC_W-1:0]         prec_in;
    logic signed [LIN_W-1:0]   lin_full;
    logic signed [QUAD_W-1:0]  quad_new;
    logic signed [LIN_W-1:0]   lin_mem [MAX_COMPONENTS];
    logic signed [QUAD_W-1:0]  quad_mem [MAX_COMPONENTS];
    logic signed [VAL_W-1:0]   x;
    logic [XSQ_W-1:0]          xsq;
    logic signed [LIN_W-1:0]   rd_lin;
    logic signed [QUAD_W-1:0]  rd_quad;
    logic signed [PLIN_W-1:0]  p_lin;
    logic signed [PQUAD_W-1:0] p_quad;

    if (d == 0) begin : g_first
      assign value_in = value_0;
      assign prec_in  = prec_0;
    end else begin : g_second
      assign value_in = value_1;
      assign prec_in  = prec_1;
    end

    assign lin_full = value_in * $signed({1'b0, prec_in});
    assign quad_new = QUAD_W'(0) - $signed({1'b0, prec_in});

    always_ff @(posedge clk) begin
      if (write_ok) begin
        lin_mem[waddr]  <= lin_full;
        quad_mem[waddr] <= quad_new;
      end
      if (cmd.capture) begin
        x <= value_in;
      end
      xsq <= XSQ_W'(x * x);
      if (advance) begin
        rd_lin  <= lin_mem[raddr];
        rd_quad <= quad_mem[raddr];
        p_lin   <= rd_lin * x;
        p_quad  <= rd_quad * $signed({1'b0, xsq});
        dim_sum[d] <= (ACC_W'(p_lin) <<< 1) + ACC_W'(p_quad);
      end
    end
  end

  always_comb begin
    total = ACC_W'(s3_const) <<< 9;
    for (int d = 0; d < DIMS; d++) begin
      total = total + dim_sum[d];
    end
  end

  assign half = total[ACC_W-1:1];

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_const      <= const_mem[raddr];
      s1_comp       <= cmd.comp;
      s1_last       <= cmd.last;
      s2_const      <= s1_const;
      s2_comp       <= s1_comp;
      s2_last       <= s1_last;
      s3_const      <= s2_const;
      s3_comp       <= s2_comp;
      s3_last       <= s2_last;
      score         <= SCORE_W'(half);
      out_component <= s3_comp;
      last          <= s3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd.issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

endmodule

/* design/gmm_diag_component_scorer_core.sv */
`timescale 1ns / 1ps

// Diagonal Gaussian mixture scorer. A load item (action 0) writes one component's
// coefficients and score constant in the cycle it is accepted. A score item
// (action 1) produces one Q40.24 score per active component, components in
// order from 0, with last set on the final one. A score item occupies the block
// until its drain is done: the sample is squared first, then one component is
// issued per cycle, while the output is not stalled, into a four-stage read,
// multiply, add and halve pipeline, and that pipeline drains before the next
// item is taken. Output stalls freeze the whole pipeline. Scoring a component
// that was never loaded gives an undefined score. The component count register
// may be written at any time the block is idle.

module gmm_diag_component_scorer_core import gmm_pkg::*; #(
  parameter int MAX_COMPONENTS = 16,
  parameter int DIMS           = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [COMP_W-1:0]         component,
  input  logic signed [VAL_W-1:0]   value_0,
  input  logic signed [VAL_W-1:0]   value_1,
  input  logic [PREC_W-1:0]         prec_0,
  input  logic [PREC_W-1:0]         prec_1,
  input  logic signed [CONST_W-1:0] comp_constant,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COMP_W-1:0]         out_component,
  output logic signed [SCORE_W-1:0] score,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [NUM_W-1:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gmm_ctrl #(
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .cmd      (cmd)
  );

  gmm_datapath #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .DIMS          (DIMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .component    (component),
    .value_0      (value_0),
    .value_1      (value_1),
    .prec_0       (prec_0),
    .prec_1       (prec_1),
    .comp_constant(comp_constant),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_component(out_component),
    .score        (score),
    .last         (last)
  );

  // A new item is never taken while a score is still waiting to transfer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a score is pending");

  // The final score of a sample leaves the pipeline empty.
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !out_valid)
    else $error("score after the last transfer of a sample");

  // Accepting a score item makes the block busy on the next cycle.
  a_score_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACTION_SCORE)) |=> !in_ready)
    else $error("input ready right after a score item");

endmodule
